>>> rtl/core/event_counter_latency_percentile_defines.svh
// assertion macros
`ifndef EVENT_COUNTER_LATENCY_PERCENTILE_DEFINES_SVH
`define EVENT_COUNTER_LATENCY_PERCENTILE_DEFINES_SVH

`define ECLP_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication failed");

`define ECLP_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle implication failed");

`endif

>>> rtl/core/eclp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package eclp_pkg;
    localparam int SAMPLE_DEPTH_DEF = 1024;
    localparam int LATENCY_BITS_DEF = 16;
    localparam int COUNTER_BITS_DEF = 32;

    localparam logic [2:0] ACT_OK     = 3'd0;
    localparam logic [2:0] ACT_FAIL   = 3'd1;
    localparam logic [2:0] ACT_RECON  = 3'd2;
    localparam logic [2:0] ACT_DROP   = 3'd3;
    localparam logic [2:0] ACT_SENT   = 3'd4;
    localparam logic [2:0] ACT_REPORT = 3'd5;
    localparam logic [2:0] ACT_DUMP   = 3'd6;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] latency_ms;
    } t_req;

    typedef struct packed {
        logic        is_dump;
        logic [31:0] sent_overall;
        logic [31:0] sent_recent;
        logic [31:0] connect_ok_count;
        logic [31:0] connect_fail_count;
        logic [31:0] reconnect_count;
        logic [31:0] drop_count;
        logic [15:0] median_ms;
        logic [15:0] p95_ms;
        logic [15:0] p99_ms;
        logic        samples_lost;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic event_upd;   // apply counting event from request
        logic scan_clr;    // start a counting pass for one candidate
        logic scan_acc;    // accumulate rank counts for read data
        logic cand_next;   // evaluate pass result and step candidate
        logic emit;        // drive result
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic last_addr;
        logic last_cand;
    } t_sts;
endpackage
`default_nettype wire

>>> rtl/core/eclp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module eclp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/eclp_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module eclp_datapath #(
    parameter int SAMPLE_DEPTH = eclp_pkg::SAMPLE_DEPTH_DEF,
    parameter int LATENCY_BITS = eclp_pkg::LATENCY_BITS_DEF,
    parameter int COUNTER_BITS = eclp_pkg::COUNTER_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire eclp_pkg::t_req i_req,
    input  wire eclp_pkg::t_cmd i_cmd,
    output eclp_pkg::t_sts     o_sts,
    output eclp_pkg::t_res     o_res
);
    import eclp_pkg::*;

    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int NW = $clog2(SAMPLE_DEPTH + 1);
    localparam int RSH = 30;
    localparam int PRW = NW + RSH;
    // p times the reciprocal of 100 scaled by 2^30, exact for (n-1)*p below 2^30/76
    localparam logic [RSH-1:0] K50 = RSH'(50 * 10737419);
    localparam logic [RSH-1:0] K95 = RSH'(95 * 10737419);
    localparam logic [RSH-1:0] K99 = RSH'(99 * 10737419);
    localparam logic [COUNTER_BITS-1:0] CMAX = '1;

    logic [COUNTER_BITS-1:0] r_total, r_recent, r_ok, r_fail, r_recon, r_drop;
    logic [NW-1:0]           r_count;
    logic                    r_ovf;
    logic [AW-1:0]           r_addr;
    logic                    r_acc_d;
    logic [AW-1:0]           r_cand;
    logic [NW-1:0]           r_less, r_leq;
    logic [NW-1:0]           r_idx [3];
    logic [LATENCY_BITS-1:0] r_pct [3];
    logic [LATENCY_BITS-1:0] w_rdata, w_cval;
    logic [LATENCY_BITS-1:0] w_lat;
    logic                    w_we;
    logic [NW-1:0]           w_nm1;
    logic [PRW-1:0]          w_p50, w_p95, w_p99;

    function automatic logic [COUNTER_BITS-1:0] sat(input logic [COUNTER_BITS-1:0] v);
        sat = (v == CMAX) ? v : v + 1'b1;
    endfunction

    // latency masked to LATENCY_BITS
    always_comb begin
        w_lat = '0;
        for (int b = 0; b < LATENCY_BITS; b++) begin
            w_lat[b] = (b < 16) ? i_req.latency_ms[b % 16] : 1'b0;
        end
    end

    assign w_we = i_cmd.event_upd && i_req.action == ACT_SENT
                  && r_count < NW'(SAMPLE_DEPTH);
    assign w_nm1 = r_count - 1'b1;
    assign w_p50 = PRW'(w_nm1) * PRW'(K50);
    assign w_p95 = PRW'(w_nm1) * PRW'(K95);
    assign w_p99 = PRW'(w_nm1) * PRW'(K99);

    // one ram port reads samples; candidate values come from a second copy
    eclp_ram #(.WIDTH(LATENCY_BITS), .DEPTH(SAMPLE_DEPTH)) u_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_count[AW-1:0]), .i_wdata(w_lat),
        .i_raddr(r_addr), .o_rdata(w_rdata)
    );
    eclp_ram #(.WIDTH(LATENCY_BITS), .DEPTH(SAMPLE_DEPTH)) u_cram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(r_count[AW-1:0]), .i_wdata(w_lat),
        .i_raddr(r_cand), .o_rdata(w_cval)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0; r_recent <= '0; r_ok <= '0; r_fail <= '0;
            r_recon <= '0; r_drop <= '0; r_count <= '0; r_ovf <= 1'b0;
            r_acc_d <= 1'b0;
        end else begin
            r_acc_d <= i_cmd.scan_acc;
            if (i_cmd.event_upd) begin
                case (i_req.action)
                    ACT_OK:    r_ok    <= sat(r_ok);
                    ACT_FAIL:  r_fail  <= sat(r_fail);
                    ACT_RECON: r_recon <= sat(r_recon);
                    ACT_DROP:  r_drop  <= sat(r_drop);
                    ACT_SENT: begin
                        r_total  <= sat(r_total);
                        r_recent <= sat(r_recent);
                        if (r_count < NW'(SAMPLE_DEPTH)) begin
                            r_count <= r_count + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.emit && i_req.action == ACT_REPORT) begin
                r_recent <= '0;
            end
        end
    end

    // rank scan: for candidate c, count samples < v and <= v; v is the
    // k-th smallest where less <= k < leq
    always_ff @(posedge i_clk) begin
        if (i_cmd.event_upd) begin
            r_cand <= '0;
            r_idx[0] <= w_p50[RSH +: NW];
            r_idx[1] <= w_p95[RSH +: NW];
            r_idx[2] <= w_p99[RSH +: NW];
            for (int k = 0; k < 3; k++) r_pct[k] <= '0;
        end
        if (i_cmd.scan_clr) begin
            r_addr <= '0;
            r_less <= '0;
            r_leq  <= '0;
        end else if (i_cmd.scan_acc) begin
            r_addr <= r_addr + 1'b1;
        end
        if (r_acc_d) begin
            if (w_rdata < w_cval) r_less <= r_less + 1'b1;
            if (w_rdata <= w_cval) r_leq <= r_leq + 1'b1;
        end
        if (i_cmd.cand_next) begin
            for (int k = 0; k < 3; k++) begin
                if (r_less <= r_idx[k] && r_idx[k] < r_leq) r_pct[k] <= w_cval;
            end
            r_cand <= r_cand + 1'b1;
        end
    end

    assign o_sts.empty     = (r_count == '0);
    assign o_sts.last_addr = (NW'(r_addr) == r_count - 1'b1);
    assign o_sts.last_cand = (NW'(r_cand) == r_count - 1'b1);

    always_comb begin
        o_res = '0;
        o_res.is_dump            = (i_req.action == ACT_DUMP);
        o_res.sent_overall       = 32'(r_total);
        o_res.sent_recent        = 32'(r_recent);
        o_res.connect_ok_count   = 32'(r_ok);
        o_res.connect_fail_count = 32'(r_fail);
        o_res.reconnect_count    = 32'(r_recon);
        o_res.drop_count         = 32'(r_drop);
        if (i_req.action == ACT_DUMP) begin
            o_res.median_ms = 16'(r_pct[0]);
            o_res.p95_ms    = 16'(r_pct[1]);
            o_res.p99_ms    = 16'(r_pct[2]);
        end
        o_res.samples_lost = r_ovf;
    end
endmodule
`default_nettype wire

>>> rtl/core/eclp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module eclp_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [2:0]     i_action,
    input  wire eclp_pkg::t_sts i_sts,
    output logic                o_busy,
    output eclp_pkg::t_cmd      o_cmd
);
    import eclp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CLR, S_SCAN, S_DRAIN, S_EVAL, S_OUT} t_state;
    t_state r_state, n_state;
    logic   r_busy;

    always_comb begin
        o_cmd = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.event_upd = 1'b1;
                    if (i_action == ACT_REPORT) begin
                        n_state = S_OUT;
                    end else if (i_action == ACT_DUMP) begin
                        n_state = S_CLR;
                    end
                end
            end
            S_CLR: begin
                if (i_sts.empty) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_acc = 1'b1;
                if (i_sts.last_addr) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_EVAL;
            S_EVAL: begin
                o_cmd.cand_next = 1'b1;
                n_state = i_sts.last_cand ? S_OUT : S_CLR;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;
endmodule
`default_nettype wire

>>> rtl/core/event_counter_latency_percentile.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  | direction | handshake          | payload
// request  | in        | start & !busy      | i_req (action, latency_ms)
// result   | out       | o_valid strobe     | o_res
// counting events update the counters on acceptance, leaving the block free for the next
// request; a report shows its result in the cycle after acceptance. a dump ranks each
// stored value by one pass over the sample ram; an empty store skips the passes.
// reset is synchronous and clears all event counters and the sample count.
// the receiver cannot stall; each result shows for one cycle.
module event_counter_latency_percentile #(
    parameter int SAMPLE_DEPTH = eclp_pkg::SAMPLE_DEPTH_DEF,
    parameter int LATENCY_BITS = eclp_pkg::LATENCY_BITS_DEF,
    parameter int COUNTER_BITS = eclp_pkg::COUNTER_BITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire eclp_pkg::t_req i_req,
    output logic                o_valid,
    output eclp_pkg::t_res      o_res
);
    import eclp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    t_req r_req;
    logic w_acc;

    assign w_acc = start && !busy;

    always_ff @(posedge i_clk) begin
        if (w_acc) r_req <= i_req;
    end

    eclp_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_acc), .i_action(i_req.action),
        .i_sts(w_sts), .o_busy(busy), .o_cmd(w_cmd)
    );

    t_req w_dreq;
    assign w_dreq = w_cmd.event_upd ? i_req : r_req;

    eclp_datapath #(
        .SAMPLE_DEPTH(SAMPLE_DEPTH), .LATENCY_BITS(LATENCY_BITS),
        .COUNTER_BITS(COUNTER_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .i_cmd(w_cmd),
        .o_sts(w_sts), .o_res(o_res)
    );

    assign o_valid = w_cmd.emit;
endmodule
`default_nettype wire

>>> rtl/core/eclp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "event_counter_latency_percentile_defines.svh"
module eclp_checker (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           o_valid,
    input wire eclp_pkg::t_res o_res
);
    `ECLP_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, busy)
    `ECLP_ASSERT_NEXT(a_valid_once, i_clk, i_rst_n, o_valid, !o_valid)
    `ECLP_ASSERT_IMP(a_report_no_pct, i_clk, i_rst_n, o_valid && !o_res.is_dump,
        o_res.median_ms == 16'd0 && o_res.p95_ms == 16'd0 && o_res.p99_ms == 16'd0)
    `ECLP_ASSERT_IMP(a_pct_order, i_clk, i_rst_n, o_valid && o_res.is_dump,
        o_res.median_ms <= o_res.p95_ms && o_res.p95_ms <= o_res.p99_ms)
endmodule

bind event_counter_latency_percentile eclp_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .o_valid(o_valid), .o_res(o_res)
);
`default_nettype wire
